### src/vst_pkg.sv
// Shared types and constants for the voxel shell test block.
package vst_pkg;

  // Mask geometry.
  localparam int MAX_SIDE = 64;
  localparam int COORD_W  = $clog2(MAX_SIDE);
  localparam int ADDR_W   = 3 * COORD_W;
  localparam int SIZE_W   = 7;
  localparam logic [SIZE_W-1:0] SIZE_MAX  = SIZE_W'(MAX_SIDE);
  localparam logic [SIZE_W-1:0] SIZE_RST  = SIZE_W'(64);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

  // Item commands.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Effective volume size along each axis, clamped to the mask side.
  typedef struct packed {
    logic [SIZE_W-1:0] x;
    logic [SIZE_W-1:0] y;
    logic [SIZE_W-1:0] z;
  } vol_size_t;

  // A finished query result offered to the output register.
  typedef struct packed {
    logic valid;
    logic shell;
    logic oor;
  } finish_t;

endpackage

### src/vst_mask_ram.sv
// Single-port synchronous RAM with a registered read.
module vst_mask_ram #(
  parameter int ADDR_W = 18,
  parameter int DATA_W = 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // One access per cycle: an optional write, and a read of the old data into the output register.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### src/vst_ctrl.sv
// Sequencer that walks a query through the center voxel and its six faces.
module vst_ctrl import vst_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic [COORD_W-1:0] coord_x,
  input  logic [COORD_W-1:0] coord_y,
  input  logic [COORD_W-1:0] coord_z,
  input  logic               inside_req,
  input  vol_size_t          vol,
  input  logic               slot_free,
  output logic               mem_we,
  output logic [ADDR_W-1:0]  mem_addr,
  output logic               mem_wdata,
  input  logic               mem_rdata,
  output finish_t            fin
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  // Face whose data arrives once the center has been seen, in walk order.
  localparam logic [2:0] LOC_XP   = 3'd0;
  localparam logic [2:0] LOC_XM   = 3'd1;
  localparam logic [2:0] LOC_YP   = 3'd2;
  localparam logic [2:0] LOC_YM   = 3'd3;
  localparam logic [2:0] LOC_ZP   = 3'd4;
  localparam logic [2:0] LOC_ZM   = 3'd5;

  logic [1:0]         state, state_next;
  logic [2:0]         cur, cur_next;
  logic [2:0]         sel;
  logic               center_seen, center_seen_next;
  logic [COORD_W-1:0] qx, qy, qz;
  logic               hold_shell, hold_oor;
  logic               accept;
  logic               in_vol;
  logic [COORD_W-1:0] nx, ny, nz;
  logic               n_inside;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_vol   = ({1'b0, coord_x} < vol.x) && ({1'b0, coord_y} < vol.y) &&
                    ({1'b0, coord_z} < vol.z);

  // The face to address next: the first one after the center, else the one after cur.
  assign sel = center_seen ? (cur + 3'd1) : cur;

  // Neighbor coordinate and volume check for the selected face.
  always_comb begin
    nx = qx;
    ny = qy;
    nz = qz;
    n_inside = 1'b1;
    unique case (sel)
      LOC_XP: begin
        nx = qx + COORD_W'(1);
        n_inside = (({1'b0, qx}) + SIZE_W'(1)) < vol.x;
      end
      LOC_XM: begin
        nx = qx - COORD_W'(1);
        n_inside = (qx != '0);
      end
      LOC_YP: begin
        ny = qy + COORD_W'(1);
        n_inside = (({1'b0, qy}) + SIZE_W'(1)) < vol.y;
      end
      LOC_YM: begin
        ny = qy - COORD_W'(1);
        n_inside = (qy != '0);
      end
      LOC_ZP: begin
        nz = qz + COORD_W'(1);
        n_inside = (({1'b0, qz}) + SIZE_W'(1)) < vol.z;
      end
      LOC_ZM: begin
        nz = qz - COORD_W'(1);
        n_inside = (qz != '0);
      end
      default: begin
        n_inside = 1'b1;
      end
    endcase
  end

  // Next state, memory port and finished result.
  always_comb begin
    state_next       = state;
    cur_next         = cur;
    center_seen_next = center_seen;
    mem_we           = 1'b0;
    mem_addr         = {coord_x, coord_y, coord_z};
    mem_wdata        = inside_req;
    fin              = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd == CMD_WRITE) begin
            mem_we = 1'b1;
          end else if (!in_vol) begin
            fin = '{valid: 1'b1, shell: 1'b0, oor: 1'b1};
          end else begin
            state_next       = S_RUN;
            center_seen_next = 1'b0;
            cur_next         = LOC_XP;
          end
        end
      end
      S_RUN: begin
        mem_addr = {nx, ny, nz};
        if (!center_seen) begin
          // Center voxel data: clear means no shell, else check the first face.
          if (!mem_rdata) begin
            fin = '{valid: 1'b1, shell: 1'b0, oor: 1'b0};
          end else if (!n_inside) begin
            fin = '{valid: 1'b1, shell: 1'b1, oor: 1'b0};
          end else begin
            center_seen_next = 1'b1;
          end
        end else if (!mem_rdata) begin
          // A clear face neighbor makes a shell voxel.
          fin = '{valid: 1'b1, shell: 1'b1, oor: 1'b0};
        end else if (cur == LOC_ZM) begin
          fin = '{valid: 1'b1, shell: 1'b0, oor: 1'b0};
        end else if (!n_inside) begin
          // The next face lies outside the volume.
          fin = '{valid: 1'b1, shell: 1'b1, oor: 1'b0};
        end else begin
          // Move to the next face; its read is issued now.
          cur_next = cur + 3'd1;
        end
      end
      S_HOLD: begin
        fin = '{valid: 1'b1, shell: hold_shell, oor: hold_oor};
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (fin.valid && state != S_HOLD) begin
      state_next = slot_free ? S_IDLE : S_HOLD;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cur         <= LOC_XP;
      center_seen <= 1'b0;
    end else begin
      state       <= state_next;
      cur         <= cur_next;
      center_seen <= center_seen_next;
    end
  end

  // Query coordinate and held result.
  always_ff @(posedge clk) begin
    if (accept) begin
      qx <= coord_x;
      qy <= coord_y;
      qz <= coord_z;
    end
    if (fin.valid && state != S_HOLD) begin
      hold_shell <= fin.shell;
      hold_oor   <= fin.oor;
    end
  end

endmodule

### src/voxel_shell_test.sv
// Top level of the voxel shell test block: configuration, mask RAM and output register.
// A write or an out-of-range query is done in the cycle of its transfer; the result goes to the output register.
// An in-range query reads the mask once per cycle, center first, then up to six faces:
// its result is registered into the output register, and the next item is taken after the walk ends.
// A full output register holds a finished result until its transfer, stalling the input.
// Reset sets all sizes to 64 and empties the output; the mask is not cleared.
module voxel_shell_test import vst_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cmd,
  input  logic [COORD_W-1:0]   coord_x,
  input  logic [COORD_W-1:0]   coord_y,
  input  logic [COORD_W-1:0]   coord_z,
  input  logic                 inside_req,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 shell,
  output logic                 out_of_range
);

  logic [SIZE_W-1:0] size_x, size_y, size_z;
  vol_size_t         vol;
  logic              slot_free;
  finish_t           fin;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_wdata;
  logic              mem_rdata;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_RST;
      size_y <= SIZE_RST;
      size_z <= SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SIZE_X: size_x <= cfg_data;
        CFG_SIZE_Y: size_y <= cfg_data;
        CFG_SIZE_Z: size_z <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sizes beyond the mask side act as the mask side.
  assign vol.x = (size_x > SIZE_MAX) ? SIZE_MAX : size_x;
  assign vol.y = (size_y > SIZE_MAX) ? SIZE_MAX : size_y;
  assign vol.z = (size_z > SIZE_MAX) ? SIZE_MAX : size_z;

  vst_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .inside_req (inside_req),
    .vol        (vol),
    .slot_free  (slot_free),
    .mem_we     (mem_we),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata),
    .fin        (fin)
  );

  vst_mask_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (1)
  ) u_mask (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Output register; it is free when empty or its transfer completes now.
  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin.valid && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.valid && slot_free) begin
      shell        <= fin.shell;
      out_of_range <= fin.oor;
    end
  end

endmodule
